/* sv/uesc_pkg.sv */
// Shared constants, types and helpers for the unicode escape unescaper.
package uesc_pkg;

	localparam int WIN_DEPTH = 10;
	localparam int CNT_W     = 4;
	localparam int CODE_W    = 32;
	localparam int STEP_W    = 3;

	localparam logic [7:0] CHR_BSLASH = 8'h5C;
	localparam logic [7:0] CHR_LOW_U  = 8'h75;
	localparam logic [7:0] CHR_UP_U   = 8'h55;

	// pending count just before the final hex digit of a short or long escape
	localparam logic [CNT_W-1:0] SHORT_LAST = 4'd5;
	localparam logic [CNT_W-1:0] LONG_LAST  = 4'd9;

	typedef struct packed {
		logic load;
		logic step;
	} enc_ctl_t;

	typedef struct packed {
		logic       valid;
		logic       last;
		logic [7:0] data;
	} enc_stat_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} hex_t;

	function automatic hex_t hex_decode(input logic [7:0] c);
		hex_t       h;
		logic [7:0] d;
		h = '0;
		d = '0;
		if (c >= 8'h30 && c <= 8'h39) begin
			d = c - 8'h30;
			h.ok = 1'b1;
			h.val = d[3:0];
		end else if (c >= 8'h61 && c <= 8'h66) begin
			d = c - 8'h57;
			h.ok = 1'b1;
			h.val = d[3:0];
		end else if (c >= 8'h41 && c <= 8'h46) begin
			d = c - 8'h37;
			h.ok = 1'b1;
			h.val = d[3:0];
		end
		return h;
	endfunction

endpackage

/* sv/uesc_in_if.sv */
// Input channel: one escaped byte per item with a final flag.
interface uesc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_final;

	modport source (output valid, output in_byte, output in_final, input ready);
	modport sink (input valid, input in_byte, input in_final, output ready);
endinterface

/* sv/uesc_out_if.sv */
// Output channel: one unescaped byte per item with run and string end marks.
interface uesc_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       run_last;
	logic       string_end;

	modport source (output valid, output out_byte, output run_last, output string_end,
		input ready);
	modport sink (input valid, input out_byte, input run_last, input string_end,
		output ready);
endinterface

/* sv/unicode_escape_unescaper.sv */
// Unicode escape unescaper: \uXXXX and \UXXXXXXXX to extended UTF-8, one byte per item.
// A byte that ends an escape or passes through is registered in the sequencer state and
// then in the output register; a finished escape also passes the encoder's sizing state.
// A held byte is taken while idle with no output; no new byte is taken while raw bytes
// or code point bytes go out; the single output register sets the pace and can stall.
// Reset: window empty, sequencer idle, output register empty.
module unicode_escape_unescaper import uesc_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	uesc_in_if.sink esc,
	uesc_out_if.source utf
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RAW  = 3'b010,
		ST_CODE = 3'b100
	} seq_state_t;

	seq_state_t        state_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [7:0]        win_q [WIN_DEPTH];
	logic              big_q;
	logic [CODE_W-1:0] code_q;
	logic [7:0]        b_q;
	logic              fin_q;
	logic [CNT_W-1:0]  raw_n_q;
	logic [CNT_W-1:0]  rd_q;
	logic              emit_b_q;
	logic              keep_b_q;

	logic              ov_q;
	logic [7:0]        ob_q;
	logic              olast_q;
	logic              oend_q;

	logic              accept;
	logic              load_ok;
	hex_t              hx;
	logic              is_bs;
	logic              is_u;
	logic              digit_last;
	logic              act_keep;
	logic              act_raw;
	logic              act_code;
	logic [CNT_W-1:0]  raw_n;
	logic              emit_b;
	logic              keep_b;

	logic              raw_more;
	logic [7:0]        raw_byte;
	logic              raw_last;
	logic              raw_go;
	logic              code_step;

	logic              win_we;
	logic [CNT_W-1:0]  win_wa;
	logic [7:0]        win_wd;

	enc_ctl_t          enc_ctl;
	enc_stat_t         enc_stat;

	assign esc.ready = (state_q == ST_IDLE);
	assign accept    = esc.valid && esc.ready;
	// the output register takes a new item when empty or being drained
	assign load_ok   = !ov_q || utf.ready;

	assign hx    = hex_decode(esc.in_byte);
	assign is_bs = (esc.in_byte == CHR_BSLASH);
	assign is_u  = (esc.in_byte == CHR_LOW_U) || (esc.in_byte == CHR_UP_U);
	assign digit_last = (cnt_q == (big_q ? LONG_LAST : SHORT_LAST));

	// Classify the new byte against the pending prefix. The window only ever
	// holds a valid, unfinished escape prefix, so a broken escape always releases the
	// whole window raw; after a bad hex digit the new byte is scanned afresh.
	always_comb begin
		act_keep = 1'b0;
		act_raw  = 1'b0;
		act_code = 1'b0;
		raw_n    = cnt_q;
		emit_b   = 1'b1;
		keep_b   = 1'b0;
		if (cnt_q == '0) begin
			if (is_bs && !esc.in_final)
				act_keep = 1'b1;
			else
				act_raw = 1'b1;
		end else if (cnt_q == 4'd1) begin
			// escape letter, or a pair that passes through
			if (is_u && !esc.in_final)
				act_keep = 1'b1;
			else
				act_raw = 1'b1;
		end else if (hx.ok) begin
			if (digit_last)
				act_code = 1'b1;
			else if (esc.in_final)
				act_raw = 1'b1;
			else
				act_keep = 1'b1;
		end else begin
			// bad digit: release the prefix, a backslash starts a new one
			act_raw = 1'b1;
			if (is_bs && !esc.in_final) begin
				emit_b = 1'b0;
				keep_b = 1'b1;
			end
		end
	end

	// raw release: window entries first, then the held byte
	assign raw_more = (rd_q < raw_n_q);
	assign raw_byte = raw_more ? win_q[rd_q] : b_q;
	assign raw_last = raw_more ? ((rd_q + 4'd1 == raw_n_q) && !emit_b_q) : 1'b1;
	assign raw_go   = (state_q == ST_RAW) && load_ok;

	assign code_step = (state_q == ST_CODE) && enc_stat.valid && load_ok;

	assign enc_ctl.load = accept && act_code;
	assign enc_ctl.step = code_step;

	uesc_utf8_enc u_enc (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (enc_ctl),
		.code   ({code_q[CODE_W-5:0], hx.val}),
		.stat   (enc_stat)
	);

	// single window write port: append on hold, or park a new backslash at the head
	always_comb begin
		win_we = 1'b0;
		win_wa = cnt_q;
		win_wd = esc.in_byte;
		if (accept && act_keep) begin
			win_we = 1'b1;
		end else if (raw_go && raw_last && keep_b_q) begin
			win_we = 1'b1;
			win_wa = '0;
			win_wd = b_q;
		end
	end

	always_ff @(posedge clk) begin
		if (win_we)
			win_q[win_wa] <= win_wd;
		if (accept) begin
			b_q <= esc.in_byte;
			fin_q <= esc.in_final;
		end
		if (accept && act_keep) begin
			// clear on the backslash and the escape letter, shift in each digit after it
			if (cnt_q < 4'd2)
				code_q <= '0;
			else
				code_q <= {code_q[CODE_W-5:0], hx.val};
			if (cnt_q == 4'd1)
				big_q <= (esc.in_byte == CHR_UP_U);
		end
		if (accept && act_raw) begin
			raw_n_q <= raw_n;
			emit_b_q <= emit_b;
			keep_b_q <= keep_b;
		end
	end

	// sequencer and pending count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			rd_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (act_keep) begin
							cnt_q <= cnt_q + 4'd1;
						end else if (act_raw) begin
							cnt_q <= keep_b ? 4'd1 : 4'd0;
							rd_q <= '0;
							state_q <= ST_RAW;
						end else begin
							cnt_q <= '0;
							state_q <= ST_CODE;
						end
					end
				end
				ST_RAW: begin
					if (raw_go) begin
						if (raw_more)
							rd_q <= rd_q + 4'd1;
						if (raw_last)
							state_q <= ST_IDLE;
					end
				end
				ST_CODE: begin
					if (code_step && enc_stat.last)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ov_q <= 1'b0;
		else if (raw_go || code_step)
			ov_q <= 1'b1;
		else if (utf.ready)
			ov_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (raw_go) begin
			ob_q <= raw_byte;
			olast_q <= raw_last;
			oend_q <= raw_last && fin_q;
		end else if (code_step) begin
			ob_q <= enc_stat.data;
			olast_q <= enc_stat.last;
			oend_q <= enc_stat.last && fin_q;
		end
	end

	assign utf.valid      = ov_q;
	assign utf.out_byte   = ob_q;
	assign utf.run_last   = olast_q;
	assign utf.string_end = oend_q;

endmodule

/* sv/uesc_utf8_enc.sv */
// Iterative UTF-8 encoder: sizes a code point, then shifts out one byte per step.
module uesc_utf8_enc import uesc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  enc_ctl_t          ctl,
	input  logic [CODE_W-1:0] code,
	output enc_stat_t         stat
);

	typedef enum logic [2:0] {
		E_IDLE = 3'b001,
		E_SIZE = 3'b010,
		E_EMIT = 3'b100
	} enc_state_t;

	enc_state_t        state_q;
	logic [CODE_W-1:0] code_q;
	logic [STEP_W-1:0] k_q;
	logic [STEP_W-1:0] k_n;
	logic [7:0]        lead_q;
	logic [7:0]        lead_n;
	logic              first_q;
	logic [CODE_W-1:0] sh;

	// byte count minus one and lead mark
	always_comb begin
		if (code_q < 32'h0000_0080) begin
			k_n = 3'd0;
			lead_n = 8'h00;
		end else if (code_q < 32'h0000_0800) begin
			k_n = 3'd1;
			lead_n = 8'hC0;
		end else if (code_q < 32'h0001_0000) begin
			k_n = 3'd2;
			lead_n = 8'hE0;
		end else if (code_q < 32'h0020_0000) begin
			k_n = 3'd3;
			lead_n = 8'hF0;
		end else if (code_q < 32'h0400_0000) begin
			k_n = 3'd4;
			lead_n = 8'hF8;
		end else begin
			k_n = 3'd5;
			lead_n = 8'hFC;
		end
	end

	// shared shifter: six bits per remaining byte
	always_comb begin
		case (k_q)
			3'd0: sh = code_q;
			3'd1: sh = code_q >> 6;
			3'd2: sh = code_q >> 12;
			3'd3: sh = code_q >> 18;
			3'd4: sh = code_q >> 24;
			3'd5: sh = code_q >> 30;
			default: sh = code_q;
		endcase
	end

	assign stat.valid = (state_q == E_EMIT);
	assign stat.last  = (k_q == '0);
	assign stat.data  = first_q ? (sh[7:0] | lead_q) : {2'b10, sh[5:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= E_IDLE;
			k_q <= '0;
			first_q <= 1'b0;
		end else begin
			unique case (state_q)
				E_IDLE: begin
					if (ctl.load)
						state_q <= E_SIZE;
				end
				E_SIZE: begin
					k_q <= k_n;
					first_q <= 1'b1;
					state_q <= E_EMIT;
				end
				E_EMIT: begin
					if (ctl.step) begin
						first_q <= 1'b0;
						if (k_q == '0)
							state_q <= E_IDLE;
						else
							k_q <= k_q - 3'd1;
					end
				end
				default: state_q <= E_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == E_IDLE && ctl.load)
			code_q <= code;
		if (state_q == E_SIZE)
			lead_q <= lead_n;
	end

endmodule
